// ----- hdl/ipv4_receive_header_check_defines.svh -----
// Assertion macros for the IPv4 receive header check.
`ifndef IPV4_RECEIVE_HEADER_CHECK_DEFINES_SVH
`define IPV4_RECEIVE_HEADER_CHECK_DEFINES_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define IPV4RX_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ipv4rx same-cycle check failed");

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define IPV4RX_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ipv4rx next-cycle check failed");

`endif

// ----- hdl/ipv4rx_pkg.sv -----
// Types, codes and helper functions shared by the IPv4 receive header check.
`default_nettype none
package ipv4rx_pkg;

	localparam int HdrBytes = 20;
	localparam int PosW     = 5;

	// Configuration register indexes
	localparam logic [1:0] REG_OWN_ADDRESS     = 2'd0;
	localparam logic [1:0] REG_NET_MASK        = 2'd1;
	localparam logic [1:0] REG_GATEWAY_ADDRESS = 2'd2;

	// Verdict codes
	localparam logic [2:0] ST_UNICAST   = 3'd0;
	localparam logic [2:0] ST_BROADCAST = 3'd1;
	localparam logic [2:0] ST_BAD_HDR   = 3'd2;
	localparam logic [2:0] ST_FRAGMENT  = 3'd3;
	localparam logic [2:0] ST_NOT_US    = 3'd4;

	// Protocol classes
	localparam logic [1:0] CL_ICMP    = 2'd0;
	localparam logic [1:0] CL_UDP     = 2'd1;
	localparam logic [1:0] CL_IGMPTCP = 2'd2;
	localparam logic [1:0] CL_OTHER   = 2'd3;

	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_IGMP = 8'd2;
	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;

	localparam logic [3:0]  IP_VERSION4 = 4'd4;
	localparam logic [15:0] SUM_GOOD    = 16'hFFFF;
	localparam logic [7:0]  OCTET_ONES  = 8'hFF;

	typedef struct packed {
		logic [7:0] header_byte;
		logic       first;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] protocol;
		logic [1:0] protocol_class;
		logic [7:0] last_protocol;
	} out_item_t;

	// Header fields handed from the byte tracker to the verdict logic
	typedef struct packed {
		logic        done;
		logic [15:0] sum;
		logic [3:0]  version;
		logic [15:0] flags;
		logic [7:0]  protocol;
		logic [31:0] dest;
	} hdr_info_t;

	// Ones-complement add with end-around carry
	function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		logic [16:0] f;
		s = {1'b0, a} + {1'b0, b};
		f = {1'b0, s[15:0]} + {16'd0, s[16]};
		return f[15:0];
	endfunction

	function automatic logic [1:0] class_of(input logic [7:0] pr);
		logic [1:0] c;
		if (pr == PROTO_ICMP) c = CL_ICMP;
		else if (pr == PROTO_UDP) c = CL_UDP;
		else if (pr == PROTO_IGMP || pr == PROTO_TCP) c = CL_IGMPTCP;
		else c = CL_OTHER;
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/ipv4rx_accum.sv -----
// Byte tracker: position count, running checksum and captured header fields.
`default_nettype none
module ipv4rx_accum (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  fire,
	input  wire ipv4rx_pkg::in_item_t  item,
	output ipv4rx_pkg::hdr_info_t      info
);
	import ipv4rx_pkg::*;

	logic [PosW-1:0] pos_q;
	logic [15:0]     sum_q;
	logic [7:0]      high_q;
	logic [3:0]      version_q;
	logic [15:0]     flags_q;
	logic [7:0]      proto_q;
	logic [31:0]     dest_q;

	logic [PosW-1:0] pos_eff;
	logic [15:0]     sum_eff;
	logic [15:0]     word;
	logic [15:0]     sum_new;
	logic            active;

	// A first mark restarts the count and the sum
	assign pos_eff = item.first ? '0 : pos_q;
	assign sum_eff = item.first ? '0 : sum_q;
	assign active  = pos_eff < PosW'(HdrBytes);
	assign word    = {high_q, item.header_byte};
	assign sum_new = oc_add(sum_eff, word);

	// Header is complete with this byte
	always_comb begin
		info.done     = active && (pos_eff == PosW'(HdrBytes - 1));
		info.sum      = sum_new;
		info.version  = version_q;
		info.flags    = flags_q;
		info.protocol = proto_q;
		info.dest     = {dest_q[23:0], item.header_byte};
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
		end else if (fire) begin
			if (active) begin
				pos_q <= pos_eff + PosW'(1);
				if (pos_eff[0]) sum_q <= sum_new;
				else sum_q <= sum_eff;
			end else begin
				pos_q <= pos_eff;
				sum_q <= sum_eff;
			end
		end
	end

	// Captured header fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_q    <= '0;
			version_q <= '0;
			flags_q   <= '0;
			proto_q   <= '0;
			dest_q    <= '0;
		end else if (fire && active) begin
			if (!pos_eff[0]) high_q <= item.header_byte;
			if (pos_eff == PosW'(0)) version_q <= item.header_byte[7:4];
			if (pos_eff == PosW'(7)) flags_q <= word;
			if (pos_eff == PosW'(9)) proto_q <= item.header_byte;
			if (pos_eff >= PosW'(16)) dest_q <= {dest_q[23:0], item.header_byte};
		end
	end

endmodule
`default_nettype wire

// ----- hdl/ipv4rx_verdict.sv -----
// Verdict logic: checksum, version, fragment and address checks.
`default_nettype none
module ipv4rx_verdict (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  fire,
	input  wire ipv4rx_pkg::hdr_info_t info,
	input  wire logic [31:0]           own_address,
	input  wire logic [31:0]           net_mask,
	input  wire logic [31:0]           gateway_address,
	output ipv4rx_pkg::out_item_t      result
);
	import ipv4rx_pkg::*;

	logic [7:0] accepted_q;
	logic       bad_hdr;
	logic       fragmented;
	logic       bcast;
	logic [2:0] status;

	assign bad_hdr    = (info.sum != SUM_GOOD) || (info.version != IP_VERSION4);
	assign fragmented = info.flags[13:0] != 14'd0;

	// Broadcast test, one octet per lane
	always_comb begin
		bcast = 1'b1;
		for (int i = 0; i < 4; i++) begin
			if (net_mask[8*i +: 8] == OCTET_ONES) begin
				if (!(info.dest[8*i +: 8] == OCTET_ONES ||
						info.dest[8*i +: 8] == gateway_address[8*i +: 8]))
					bcast = 1'b0;
			end else if (info.dest[8*i +: 8] != OCTET_ONES) begin
				bcast = 1'b0;
			end
		end
	end

	// Checks in priority order
	always_comb begin
		if (bad_hdr) status = ST_BAD_HDR;
		else if (fragmented) status = ST_FRAGMENT;
		else if (bcast) status = ST_BROADCAST;
		else if (info.dest == own_address) status = ST_UNICAST;
		else status = ST_NOT_US;
	end

	always_comb begin
		result.status         = status;
		result.protocol       = info.protocol;
		result.protocol_class = class_of(info.protocol);
		result.last_protocol  = (status == ST_UNICAST || status == ST_BROADCAST) ?
			info.protocol : accepted_q;
	end

	// Protocol of the last accepted header
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accepted_q <= '0;
		end else if (fire && info.done &&
				(status == ST_UNICAST || status == ST_BROADCAST)) begin
			accepted_q <= info.protocol;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/ipv4_receive_header_check.sv -----
// Top level of the IPv4 receive header check.
//
//  channel  | signals                        | content
//  ---------+--------------------------------+------------------------------------
//  in       | in_valid, in_stall, in_data    | one header byte and first mark
//  out      | out_valid, out_stall, out_data | verdict, protocol, class, last
//  cfg      | cfg_en, cfg_index, cfg_data    | own address, net mask, gateway
//
// One byte is taken per cycle while the input does not stall; the twentieth
// byte passes through the input register, and its verdict is then loaded into
// the result register, from which it leaves once the output is not stalled.
// Reset clears byte count, checksum, captured fields, config and valid flags.
// A stalled result holds; the input stalls only when a finishing byte
// waits in the input register behind a full, stalled result register.
`default_nettype none
`include "ipv4_receive_header_check_defines.svh"
module ipv4_receive_header_check (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output      logic                  in_stall,
	input  wire ipv4rx_pkg::in_item_t  in_data,
	output      logic                  out_valid,
	input  wire logic                  out_stall,
	output ipv4rx_pkg::out_item_t      out_data,
	input  wire logic                  cfg_en,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [31:0]           cfg_data
);
	import ipv4rx_pkg::*;

	logic [31:0] own_q;
	logic [31:0] mask_q;
	logic [31:0] gw_q;

	logic        valid_s1;
	in_item_t    data_s1;
	hdr_info_t   info;
	out_item_t   result;
	logic        proceed;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q  <= '0;
			mask_q <= '0;
			gw_q   <= '0;
		end else if (cfg_en) begin
			case (cfg_index)
				REG_OWN_ADDRESS:     own_q  <= cfg_data;
				REG_NET_MASK:        mask_q <= cfg_data;
				REG_GATEWAY_ADDRESS: gw_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input byte moves on unless its verdict has nowhere to go
	assign proceed  = valid_s1 && (!info.done || !out_valid || !out_stall);
	assign in_stall = valid_s1 && !proceed;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (proceed) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) data_s1 <= in_data;
	end

	ipv4rx_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (proceed),
		.item   (data_s1),
		.info   (info)
	);

	ipv4rx_verdict u_verdict (
		.clk             (clk),
		.arst_n          (arst_n),
		.fire            (proceed),
		.info            (info),
		.own_address     (own_q),
		.net_mask        (mask_q),
		.gateway_address (gw_q),
		.result          (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (proceed && info.done) begin
			out_valid <= 1'b1;
		end else if (out_valid && !out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proceed && info.done) out_data <= result;
	end

	// Checks
	`IPV4RX_ASSERT_IMPLY(a_stall_needs_item, in_stall, valid_s1 && info.done)
	`IPV4RX_ASSERT_IMPLY(a_out_from_done, $rose(out_valid), $past(proceed && info.done))
	`IPV4RX_ASSERT_IMPLY(a_status_range, out_valid, out_data.status <= ST_NOT_US)
	`IPV4RX_ASSERT_NEXT(a_accept_last, proceed && info.done &&
		(result.status == ST_UNICAST || result.status == ST_BROADCAST),
		out_data.last_protocol == out_data.protocol)

endmodule
`default_nettype wire
